// File: rtl/core/srl_pkg.sv
// ----------------------------------------------------------------------------
// srl_pkg
// Shared types and constants for the stereo linear resampler: lane command
// and status bundles, control state encodings and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package srl_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int SRATE_W  = 16;
    localparam int ORATE_W  = 18;
    localparam int PHASE_W  = 18;
    localparam int CFG_IDX_W = 2;

    // Results per input frame, and the counter that tracks them
    localparam int CNT_W = 4;
    localparam logic [CNT_W-1:0] MAX_RESULTS = 4'd12;

    // Serial divider: the quotient magnitude is below 2^16, one bit per cycle
    localparam int DIV_STEPS = 16;
    localparam int STEP_W    = 4;
    localparam logic [STEP_W-1:0] LAST_STEP = 4'(DIV_STEPS - 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_RATE = 2'd1;

    // Register reset values
    localparam logic [SRATE_W-1:0] SRATE_RESET = 16'd32728;
    localparam logic [ORATE_W-1:0] ORATE_RESET = 18'd48000;

    // Work handed to one interpolation lane
    typedef struct packed {
        logic                       start;
        logic signed [SAMPLE_W-1:0] cur;
        logic signed [SAMPLE_W-1:0] nxt;
        logic [PHASE_W-1:0]         phase;
        logic [ORATE_W-1:0]         divisor;
    } lane_cmd_t;

    // What a lane reports back
    typedef struct packed {
        logic                       done;
        logic signed [SAMPLE_W-1:0] result;
    } lane_sts_t;

    // Request from the control into the merge stage
    typedef struct packed {
        logic valid;
        logic last;
    } push_t;

    typedef enum logic [1:0] {
        LN_IDLE,
        LN_MUL,
        LN_DIV,
        LN_FIX
    } lane_state_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_CHECK,
        C_WAIT,
        C_PUSH
    } ctrl_state_t;

endpackage

`default_nettype wire

// File: rtl/core/srl_lane.sv
// ----------------------------------------------------------------------------
// srl_lane
// One channel of the interpolator: cur + (nxt - cur) * phase / divisor,
// quotient truncated toward zero. A registered multiply, then a restoring
// divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module srl_lane (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire srl_pkg::lane_cmd_t  cmd,
    output srl_pkg::lane_sts_t       sts
);

    // Product width: remainder over dividend
    localparam int PROD_W = srl_pkg::ORATE_W + srl_pkg::SAMPLE_W;

    srl_pkg::lane_state_t state_reg, state_next;

    logic [srl_pkg::STEP_W-1:0]          step_reg, step_next;
    logic                                done_reg, done_next;
    logic signed [srl_pkg::SAMPLE_W-1:0] base_reg;
    logic signed [srl_pkg::SAMPLE_W-1:0] result_reg;
    logic                                neg_reg;
    logic [srl_pkg::SAMPLE_W-1:0]        mag_reg;
    logic [srl_pkg::PHASE_W-1:0]         phase_reg;
    logic [srl_pkg::ORATE_W-1:0]         div_reg;
    logic [srl_pkg::ORATE_W-1:0]         rem_reg;
    logic [srl_pkg::SAMPLE_W-1:0]        dvd_reg;

    // Delta and its magnitude, taken at start
    logic signed [srl_pkg::SAMPLE_W:0] delta;
    logic [srl_pkg::SAMPLE_W:0]        delta_abs;

    // Divider step
    logic [srl_pkg::ORATE_W:0] shifted;
    logic [srl_pkg::ORATE_W:0] trial;
    logic                      qbit;

    // Final signed sum
    logic signed [srl_pkg::SAMPLE_W:0] q_signed;
    logic signed [srl_pkg::SAMPLE_W:0] sum;

    assign delta     = {cmd.nxt[srl_pkg::SAMPLE_W-1], cmd.nxt}
                     - {cmd.cur[srl_pkg::SAMPLE_W-1], cmd.cur};
    assign delta_abs = delta[srl_pkg::SAMPLE_W] ? (~delta + 1'b1) : delta;

    assign shifted = {rem_reg, dvd_reg[srl_pkg::SAMPLE_W-1]};
    assign trial   = shifted - {1'b0, div_reg};
    assign qbit    = ~trial[srl_pkg::ORATE_W];

    assign q_signed = neg_reg ? -$signed({1'b0, dvd_reg}) : $signed({1'b0, dvd_reg});
    assign sum      = {base_reg[srl_pkg::SAMPLE_W-1], base_reg} + q_signed;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= srl_pkg::LN_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            srl_pkg::LN_IDLE: begin
                if (cmd.start) begin
                    state_next = srl_pkg::LN_MUL;
                end
            end
            srl_pkg::LN_MUL: begin
                step_next  = '0;
                state_next = srl_pkg::LN_DIV;
            end
            srl_pkg::LN_DIV: begin
                step_next = step_reg + 1'b1;
                if (step_reg == srl_pkg::LAST_STEP) begin
                    state_next = srl_pkg::LN_FIX;
                end
            end
            srl_pkg::LN_FIX: begin
                done_next  = 1'b1;
                state_next = srl_pkg::LN_IDLE;
            end
            default: state_next = srl_pkg::LN_IDLE;
        endcase
    end

    // Datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            srl_pkg::LN_IDLE: begin
                if (cmd.start) begin
                    base_reg  <= cmd.cur;
                    neg_reg   <= delta[srl_pkg::SAMPLE_W];
                    mag_reg   <= delta_abs[srl_pkg::SAMPLE_W-1:0];
                    phase_reg <= cmd.phase;
                    div_reg   <= cmd.divisor;
                end
            end
            srl_pkg::LN_MUL: begin
                // High part is already below the divisor since phase < divisor
                {rem_reg, dvd_reg} <= PROD_W'(mag_reg) * PROD_W'(phase_reg);
            end
            srl_pkg::LN_DIV: begin
                rem_reg <= qbit ? trial[srl_pkg::ORATE_W-1:0]
                                : shifted[srl_pkg::ORATE_W-1:0];
                dvd_reg <= {dvd_reg[srl_pkg::SAMPLE_W-2:0], qbit};
            end
            srl_pkg::LN_FIX: begin
                result_reg <= sum[srl_pkg::SAMPLE_W-1:0];
            end
            default: ;
        endcase
    end

    assign sts.done   = done_reg;
    assign sts.result = result_reg;

endmodule

`default_nettype wire

// File: rtl/core/srl_merge.sv
// ----------------------------------------------------------------------------
// srl_merge
// Joins the left and right lane results with the run flag into one output
// frame and holds it in the master-side register until transferred.
// ----------------------------------------------------------------------------
`default_nettype none

module srl_merge (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire srl_pkg::push_t      push,
    input  wire srl_pkg::lane_sts_t  left_sts,
    input  wire srl_pkg::lane_sts_t  right_sts,
    output logic                     push_ready,
    output logic                     m_tvalid,
    input  wire                      m_tready,
    output logic [31:0]              m_tdata,   // [15:0] left_out, [31:16] right_out
    output logic                     m_tlast    // last_of_run
);

    logic        tvalid_reg;
    logic [31:0] tdata_reg;
    logic        tlast_reg;

    assign push_ready = !tvalid_reg || m_tready;

    // Valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tvalid_reg <= 1'b0;
        end else if (push.valid && push_ready) begin
            tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            tvalid_reg <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (push.valid && push_ready) begin
            tdata_reg <= {right_sts.result, left_sts.result};
            tlast_reg <= push.last;
        end
    end

    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tlast  = tlast_reg;

endmodule

`default_nettype wire

// File: rtl/core/stereo_linear_resampler_top.sv
// ----------------------------------------------------------------------------
// stereo_linear_resampler_top
// Linear interpolation sample rate converter for signed 16-bit stereo frames.
// ----------------------------------------------------------------------------
// Sequence: an output frame passes through the check, the multiply, 16 divider
//   steps, the fixup, the wait and the push into the output register.
// Flow: a new input frame is accepted only in idle, once the run of up to 12
//   output frames for the last one is pushed; output stalls hold the run.
// Reset: synchronous active-low aresetn clears state, phase and priming and
//   loads the source rate register with 32728 and the output rate with 48000.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_linear_resampler_top (
    input  wire         aclk,
    input  wire         aresetn,
    // configuration
    input  wire         cfg_wr_en,
    input  wire [1:0]   cfg_index,
    input  wire [17:0]  cfg_wdata,
    // source frames
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [31:0]  s_tdata,   // [15:0] left_in, [31:16] right_in
    // output frames
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // [15:0] left_out, [31:16] right_out
    output logic        m_tlast    // last_of_run
);

    srl_pkg::ctrl_state_t state_reg, state_next;

    logic [srl_pkg::SRATE_W-1:0]         srate_reg;
    logic [srl_pkg::ORATE_W-1:0]         orate_reg;
    logic signed [srl_pkg::SAMPLE_W-1:0] cur_l_reg, cur_l_next;
    logic signed [srl_pkg::SAMPLE_W-1:0] cur_r_reg, cur_r_next;
    logic signed [srl_pkg::SAMPLE_W-1:0] nxt_l_reg, nxt_l_next;
    logic signed [srl_pkg::SAMPLE_W-1:0] nxt_r_reg, nxt_r_next;
    logic [srl_pkg::PHASE_W-1:0]         phase_reg, phase_next;
    logic [1:0]                          primed_reg, primed_next;
    logic [srl_pkg::CNT_W-1:0]           cnt_reg, cnt_next;
    logic                                last_reg, last_next;

    logic [srl_pkg::PHASE_W:0]   phase_sum;
    logic [srl_pkg::PHASE_W-1:0] phase_sat;
    logic                        can_emit;
    logic                        in_xfer;
    logic                        start;
    logic                        push_ready;

    srl_pkg::lane_cmd_t left_cmd, right_cmd;
    srl_pkg::lane_sts_t left_sts, right_sts;
    srl_pkg::push_t     push;

    assign s_tready = (state_reg == srl_pkg::C_IDLE);
    assign in_xfer  = s_tvalid && s_tready;

    assign phase_sum = {1'b0, phase_reg} + {3'b000, srate_reg};
    assign phase_sat = phase_sum[srl_pkg::PHASE_W] ? '1 : phase_sum[srl_pkg::PHASE_W-1:0];
    assign can_emit  = (phase_reg < orate_reg) && (cnt_reg < srl_pkg::MAX_RESULTS);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            srate_reg <= srl_pkg::SRATE_RESET;
            orate_reg <= srl_pkg::ORATE_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == srl_pkg::REG_SOURCE_RATE) begin
                srate_reg <= cfg_wdata[srl_pkg::SRATE_W-1:0];
            end else if (cfg_index == srl_pkg::REG_OUTPUT_RATE) begin
                orate_reg <= cfg_wdata;
            end
        end
    end

    // Control state and frame pair
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= srl_pkg::C_IDLE;
            cur_l_reg  <= '0;
            cur_r_reg  <= '0;
            nxt_l_reg  <= '0;
            nxt_r_reg  <= '0;
            phase_reg  <= '0;
            primed_reg <= '0;
            cnt_reg    <= '0;
            last_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cur_l_reg  <= cur_l_next;
            cur_r_reg  <= cur_r_next;
            nxt_l_reg  <= nxt_l_next;
            nxt_r_reg  <= nxt_r_next;
            phase_reg  <= phase_next;
            primed_reg <= primed_next;
            cnt_reg    <= cnt_next;
            last_reg   <= last_next;
        end
    end

    // Sequencer: take a frame, then emit while the phase is in range and below the cap
    always_comb begin
        state_next  = state_reg;
        cur_l_next  = cur_l_reg;
        cur_r_next  = cur_r_reg;
        nxt_l_next  = nxt_l_reg;
        nxt_r_next  = nxt_r_reg;
        phase_next  = phase_reg;
        primed_next = primed_reg;
        cnt_next    = cnt_reg;
        last_next   = last_reg;
        start       = 1'b0;
        push        = '0;
        unique case (state_reg)
            srl_pkg::C_IDLE: begin
                if (in_xfer) begin
                    cnt_next = '0;
                    if (primed_reg == 2'd0) begin
                        cur_l_next  = s_tdata[15:0];
                        cur_r_next  = s_tdata[31:16];
                        primed_next = 2'd1;
                    end else if (primed_reg == 2'd1) begin
                        nxt_l_next  = s_tdata[15:0];
                        nxt_r_next  = s_tdata[31:16];
                        primed_next = 2'd2;
                        state_next  = srl_pkg::C_CHECK;
                    end else begin
                        cur_l_next = nxt_l_reg;
                        cur_r_next = nxt_r_reg;
                        nxt_l_next = s_tdata[15:0];
                        nxt_r_next = s_tdata[31:16];
                        if (phase_reg >= orate_reg) begin
                            phase_next = phase_reg - orate_reg;
                        end
                        state_next = srl_pkg::C_CHECK;
                    end
                end
            end
            srl_pkg::C_CHECK: begin
                if (can_emit) begin
                    start      = 1'b1;
                    phase_next = phase_sat;
                    cnt_next   = cnt_reg + 1'b1;
                    last_next  = (cnt_reg == srl_pkg::MAX_RESULTS - 1'b1)
                              || (phase_sat >= orate_reg);
                    state_next = srl_pkg::C_WAIT;
                end else begin
                    state_next = srl_pkg::C_IDLE;
                end
            end
            srl_pkg::C_WAIT: begin
                if (left_sts.done) begin
                    state_next = srl_pkg::C_PUSH;
                end
            end
            srl_pkg::C_PUSH: begin
                push.valid = 1'b1;
                push.last  = last_reg;
                if (push_ready) begin
                    state_next = srl_pkg::C_CHECK;
                end
            end
            default: state_next = srl_pkg::C_IDLE;
        endcase
    end

    // Lane commands: both lanes share phase and divisor
    always_comb begin
        left_cmd.start    = start;
        left_cmd.cur      = cur_l_reg;
        left_cmd.nxt      = nxt_l_reg;
        left_cmd.phase    = phase_reg;
        left_cmd.divisor  = orate_reg;
        right_cmd.start   = start;
        right_cmd.cur     = cur_r_reg;
        right_cmd.nxt     = nxt_r_reg;
        right_cmd.phase   = phase_reg;
        right_cmd.divisor = orate_reg;
    end

    srl_lane u_lane_left (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (left_cmd),
        .sts     (left_sts)
    );

    srl_lane u_lane_right (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (right_cmd),
        .sts     (right_sts)
    );

    srl_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .left_sts   (left_sts),
        .right_sts  (right_sts),
        .push_ready (push_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    // Both lanes run in lockstep
    assert property (@(posedge aclk) disable iff (!aresetn)
        left_sts.done == right_sts.done)
        else $error("lane completion out of step");

    // Never more than the result cap per frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= srl_pkg::MAX_RESULTS)
        else $error("result count past cap");

    // A flagged last frame ends the run: control returns to idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == srl_pkg::C_PUSH && push_ready && last_reg)
        |=> ##1 (state_reg == srl_pkg::C_IDLE))
        else $error("emission continued after last frame");

    // A lane completes only while control waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        left_sts.done |-> (state_reg == srl_pkg::C_WAIT))
        else $error("lane result with no request pending");

endmodule

`default_nettype wire

// File: dv/stereo_linear_resampler_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_linear_resampler_top_tb
// Self-checking bench for the stereo linear resampler. Source frames go in on
// the s_ stream and interpolated frames come out on the m_ stream. A scoreboard
// keeps its own copy of the frame pair, the phase and the rate registers. It
// predicts every output frame, including the end-of-run flag, and compares
// each m_ transfer against the oldest prediction. Stimulus is a directed
// opening (priming, full-scale swings, rate corner cases) followed by random
// phases under varying rates, with random stalls on both sides and one long
// output back-pressure stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_linear_resampler_top_tb;

    localparam int CYCLE_LIMIT    = 1_500_000;
    localparam int SETTLE_CYCLES  = 48;
    localparam int SQUEEZE_CYCLES = 400;
    localparam int RAND_PHASES    = 12;
    localparam int PHASE_FRAMES   = 30;
    localparam int MAX_PRINTS     = 40;

    localparam logic [srl_pkg::PHASE_W-1:0]   PHASE_CAP  = {srl_pkg::PHASE_W{1'b1}};
    localparam logic [srl_pkg::ORATE_W-1:0]   ORATE_FULL = {srl_pkg::ORATE_W{1'b1}};
    // indexes past the last register; writes there are dropped by the block
    localparam logic [srl_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [srl_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic [srl_pkg::SAMPLE_W-1:0] left;
        logic [srl_pkg::SAMPLE_W-1:0] right;
        logic                         tail;
    } out_frame_t;

    // ------------------------------------------------------------------------
    // Scoreboard: interpolation predictor and queue of expected output frames
    // ------------------------------------------------------------------------
    class resampler_scoreboard;
        logic [srl_pkg::SRATE_W-1:0]         src_rate;
        logic [srl_pkg::ORATE_W-1:0]         out_rate;
        logic signed [srl_pkg::SAMPLE_W-1:0] cur_l, cur_r, nxt_l, nxt_r;
        logic [srl_pkg::PHASE_W-1:0]         phase;
        int                                  primed;
        out_frame_t                          pending[$];
        int                                  errors;

        function new();
            src_rate = srl_pkg::SRATE_RESET;
            out_rate = srl_pkg::ORATE_RESET;
            cur_l = '0; cur_r = '0; nxt_l = '0; nxt_r = '0;
            phase  = '0;
            primed = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [srl_pkg::CFG_IDX_W-1:0] idx,
                              logic [srl_pkg::ORATE_W-1:0] value);
            if (idx == srl_pkg::REG_SOURCE_RATE)
                src_rate = value[srl_pkg::SRATE_W-1:0];
            else if (idx == srl_pkg::REG_OUTPUT_RATE)
                out_rate = value;
        endfunction

        // a + (b - a) * phase / out_rate, quotient truncated toward zero
        function logic [srl_pkg::SAMPLE_W-1:0] lerp(logic signed [srl_pkg::SAMPLE_W-1:0] a,
                                                    logic signed [srl_pkg::SAMPLE_W-1:0] b);
            longint delta;
            longint quo;
            delta = longint'(b) - longint'(a);
            quo   = (delta * longint'(phase)) / longint'(out_rate);
            return srl_pkg::SAMPLE_W'(longint'(a) + quo);
        endfunction

        // emit frames while the phase is below the output rate, capped per input
        function void emit_run();
            int          n;
            logic [18:0] sum;
            out_frame_t  held;
            bit          have_held;
            n = 0;
            have_held = 0;
            while (n < int'(srl_pkg::MAX_RESULTS) && phase < out_rate) begin
                if (have_held)
                    pending.push_back(held);
                held.left  = lerp(cur_l, nxt_l);
                held.right = lerp(cur_r, nxt_r);
                held.tail  = 1'b0;
                have_held  = 1;
                n++;
                sum   = {1'b0, phase} + {3'b0, src_rate};
                phase = (sum > {1'b0, PHASE_CAP}) ? PHASE_CAP : sum[srl_pkg::PHASE_W-1:0];
            end
            if (have_held) begin
                held.tail = 1'b1;
                pending.push_back(held);
            end
        endfunction

        // one source frame accepted on the s_ side
        function void note_frame(logic [srl_pkg::SAMPLE_W-1:0] in_l,
                                 logic [srl_pkg::SAMPLE_W-1:0] in_r);
            if (primed == 0) begin
                cur_l  = in_l;
                cur_r  = in_r;
                primed = 1;
                return;
            end
            if (primed == 1) begin
                nxt_l  = in_l;
                nxt_r  = in_r;
                primed = 2;
            end else begin
                cur_l = nxt_l;
                cur_r = nxt_r;
                nxt_l = in_l;
                nxt_r = in_r;
                if (phase >= out_rate)
                    phase = phase - out_rate;
            end
            emit_run();
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTS)
                $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        // one output frame seen on the m_ side
        task check_output(logic [srl_pkg::SAMPLE_W-1:0] got_l,
                          logic [srl_pkg::SAMPLE_W-1:0] got_r,
                          logic got_tail);
            out_frame_t exp_f;
            if (pending.size() == 0) begin
                report($sformatf("unexpected frame L=%h R=%h last=%b", got_l, got_r, got_tail));
                return;
            end
            exp_f = pending.pop_front();
            if (got_l !== exp_f.left)
                report($sformatf("left_out %h, expected %h", got_l, exp_f.left));
            if (got_r !== exp_f.right)
                report($sformatf("right_out %h, expected %h", got_r, exp_f.right));
            if (got_tail !== exp_f.tail)
                report($sformatf("last %b, expected %b", got_tail, exp_f.tail));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT and signals
    // ------------------------------------------------------------------------
    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_wr_en;
    logic [srl_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [srl_pkg::ORATE_W-1:0]   cfg_wdata;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [31:0]                   s_tdata;   // [15:0] left_in, [31:16] right_in
    logic                          m_tvalid;
    logic                          m_tready;
    logic [31:0]                   m_tdata;   // [15:0] left_out, [31:16] right_out
    logic                          m_tlast;   // last_of_run

    resampler_scoreboard          board;
    bit                           s_idle_on;
    bit                           m_idle_on;
    bit                           squeeze_req;
    int                           cycle_count;
    logic [srl_pkg::SAMPLE_W-1:0] prev_l, prev_r;

    stereo_linear_resampler_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [srl_pkg::SAMPLE_W-1:0] pick_sample(
            logic [srl_pkg::SAMPLE_W-1:0] prev);
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            1, 2: return prev + srl_pkg::SAMPLE_W'($urandom_range(0, 64)) - 16'd32;
            default: return srl_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_frame(input logic [srl_pkg::SAMPLE_W-1:0] l,
                              input logic [srl_pkg::SAMPLE_W-1:0] r);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {r, l};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_frame(l, r);
        prev_l = l;
        prev_r = r;
        gap = s_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_frame(pick_sample(prev_l), pick_sample(prev_r));
    endtask

    // enable stays high across back-to-back writes; end_writes drops it
    task automatic write_reg(input logic [srl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [srl_pkg::ORATE_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        board.set_reg(idx, value);
    endtask

    task automatic end_writes();
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // stop offering, wait for every expected frame, then let the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_rates(input logic [srl_pkg::ORATE_W-1:0] src,
                             input logic [srl_pkg::ORATE_W-1:0] orate);
        drain();
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                      srl_pkg::ORATE_W'($urandom));
        write_reg(srl_pkg::REG_SOURCE_RATE, src);
        write_reg(srl_pkg::REG_OUTPUT_RATE, orate);
        end_writes();
        s_idle_on = ($urandom_range(0, 3) != 0);
        m_idle_on = ($urandom_range(0, 3) != 0);
    endtask

    // ------------------------------------------------------------------------
    // Output side: random ready, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : sink_proc
        int gap;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (squeeze_req) begin
                m_tready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge aclk);
                squeeze_req = 1'b0;
            end
            gap = m_idle_on ? pick_gap() : 0;
            if (gap == 0) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    // output monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_output(m_tdata[15:0], m_tdata[31:16], m_tlast);
    end

    // watchdog
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        logic [srl_pkg::ORATE_W-1:0] src, orate;
        board       = new();
        squeeze_req = 1'b0;
        s_idle_on   = 1'b0;
        m_idle_on   = 1'b1;
        prev_l      = '0;
        prev_r      = '0;
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= srl_pkg::REG_SOURCE_RATE;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // priming at reset rates, then full-scale swings and bit patterns
        send_frame(16'h7FFF, 16'h8000);
        send_frame(16'h8000, 16'h7FFF);
        send_frame(16'h7FFF, 16'h8000);
        send_frame(16'h0000, 16'h0000);
        send_frame(16'hFFFF, 16'h0001);
        send_frame(16'h5555, 16'hAAAA);
        send_frame(16'hAAAA, 16'h5555);
        send_frame(16'h8000, 16'h8000);
        send_frame(16'h7FFF, 16'h7FFF);
        send_frame(16'h1234, 16'hEDCB);

        // zero source rate: every frame hits the cap with identical outputs
        set_rates(18'd0, 18'd48000);
        send_frame(16'h8000, 16'h7FFF);
        send_frame(16'h4000, 16'hC000);

        // small source rate: capped runs leave the phase low for the next frame
        set_rates(18'd1000, 18'd48000);
        send_frame(16'h7FFF, 16'h8000);
        send_frame(16'h0100, 16'hFF00);

        // largest rates: the phase sum saturates
        set_rates(18'hFFFF, ORATE_FULL);
        send_frame(16'h7FFF, 16'h8000);
        send_frame(16'h8000, 16'h7FFF);

        // source well above output: most frames yield nothing
        set_rates(18'hFFFF, 18'd8000);
        send_frame(16'h1111, 16'h2222);
        send_frame(16'h3333, 16'h4444);
        send_frame(16'h5555, 16'h6666);

        // zero output rate: no output and no division
        set_rates(18'd16000, 18'd0);
        send_frame(16'h7FFF, 16'h8000);
        send_frame(16'h0001, 16'hFFFF);

        // random phases with varying rates
        for (int p = 0; p < RAND_PHASES; p++) begin
            case ($urandom_range(0, 5))
                0, 1, 2: begin
                    src   = srl_pkg::ORATE_W'($urandom_range(16000, 65535));
                    orate = srl_pkg::ORATE_W'($urandom_range(8000, 192000));
                end
                3: begin
                    src   = srl_pkg::ORATE_W'($urandom_range(0, 3000));
                    orate = srl_pkg::ORATE_W'($urandom_range(8000, 192000));
                end
                4: begin
                    src   = $urandom_range(0, 1) ? 18'd65535 : 18'd16000;
                    orate = $urandom_range(0, 1) ? 18'd192000 : 18'd8000;
                end
                default: begin
                    src   = srl_pkg::ORATE_W'($urandom);
                    orate = srl_pkg::ORATE_W'($urandom);
                end
            endcase
            // keep output traffic regular on the back-pressure phase
            if (p == 1) begin
                src   = 18'd44100;
                orate = 18'd96000;
            end
            set_rates(src, orate);
            if (p == 1) begin
                s_idle_on   = 1'b0;
                squeeze_req = 1'b1;
            end
            send_random(PHASE_FRAMES);
        end

        drain();
        if (board.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/core/srl_pkg.sv
rtl/core/srl_lane.sv
rtl/core/srl_merge.sv
rtl/core/stereo_linear_resampler_top.sv
dv/stereo_linear_resampler_top_tb.sv
